// ===== hdl/reab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reab_pkg
// Widths and codes shared by the bounded rectangle expander and its
// bit-serial root and divide units.
// ----------------------------------------------------------------------------
package reab_pkg;

  localparam int COORD_W  = 16;               // signed coordinate field
  localparam int DIM_W    = 15;               // unsigned width / height field
  localparam int GOAL_W   = 31;               // goal area
  localparam int RAD_W    = 36;               // square root radicand
  localparam int ROOT_W   = RAD_W / 2;        // square root result
  localparam int WIDE_W   = 36;               // internal coordinate arithmetic
  localparam int OFF_W    = 33;               // signed edge offset
  localparam int SQ_CNT_W = $clog2(ROOT_W);
  localparam int DV_CNT_W = $clog2(GOAL_W);
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] CFG_BOUND_X      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_BOUND_Y      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_BOUND_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_BOUND_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] CFG_GOAL_AREA    = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIV0 = 2'd1;
  localparam logic [1:0] STAT_FALL = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/reab_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reab_isqrt
// Restoring integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module reab_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [reab_pkg::RAD_W-1:0]  radicand,
  output logic                             done,
  output logic [reab_pkg::ROOT_W-1:0]      root
);

  localparam int RW = reab_pkg::ROOT_W;

  logic [reab_pkg::RAD_W-1:0]    rad_r;
  logic [RW:0]                   rem_r;
  logic [RW-1:0]                 root_r;
  logic [reab_pkg::SQ_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          ge;
  logic [RW:0]   rem_new;

  always_comb begin
    rem_sh  = {rem_r, rad_r[reab_pkg::RAD_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_new = ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r  <= rem_new;
        root_r <= {root_r[RW-2:0], ge};
        rad_r  <= {rad_r[reab_pkg::RAD_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == reab_pkg::SQ_CNT_W'(RW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ===== hdl/reab_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reab_div
// Restoring unsigned divider, goal area by a rectangle side, one quotient
// bit per cycle. The divisor must be non-zero.
// ----------------------------------------------------------------------------
module reab_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        go,
  input  wire logic [reab_pkg::GOAL_W-1:0] num,
  input  wire logic [reab_pkg::DIM_W-1:0]  den,
  output logic                             done,
  output logic [reab_pkg::GOAL_W-1:0]      quo
);

  localparam int NW = reab_pkg::GOAL_W;
  localparam int DW = reab_pkg::DIM_W;

  logic [NW-1:0]                 num_r;
  logic [DW-1:0]                 den_r;
  logic [DW-1:0]                 rem_r;
  logic [reab_pkg::DV_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_new;

  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_new = ge ? DW'(rem_sh - {1'b0, den_r}) : DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        num_r <= num;
        den_r <= den;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        // shift the quotient bit in where the dividend bit leaves
        rem_r <= rem_new;
        num_r <= {num_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == reab_pkg::DV_CNT_W'(NW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

// ===== hdl/rect_expand_to_area_bounded.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rect_expand_to_area_bounded
// Grows or shrinks a rectangle on its free edges towards a goal area,
// clipped to a bounding rectangle, over at most four rounds.
// ----------------------------------------------------------------------------
// A rectangle is taken when start is high and busy is low; its result
// appears on the out_ ports for one cycle with out_valid and must be
// captured then, as the receiver cannot stall. Each round runs the
// bit-serial square root (two radicand bits a cycle) or the bit-serial
// divider (one quotient bit a cycle), wrapped in launch, completion, offset,
// apply, clip and edge-marking steps; a round with a zero divisor skips the
// unit. The next item can be taken at the edge that transfers the result.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module rect_expand_to_area_bounded (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [reab_pkg::COORD_W-1:0] in_start_x,
  input  wire logic signed [reab_pkg::COORD_W-1:0] in_start_y,
  input  wire logic        [reab_pkg::DIM_W-1:0]   in_start_width,
  input  wire logic        [reab_pkg::DIM_W-1:0]   in_start_height,
  output logic                                     out_valid,
  output logic signed      [reab_pkg::COORD_W-1:0] out_x,
  output logic signed      [reab_pkg::COORD_W-1:0] out_y,
  output logic             [reab_pkg::DIM_W-1:0]   out_width,
  output logic             [reab_pkg::DIM_W-1:0]   out_height,
  output logic             [1:0]                   out_status,
  input  wire logic                                cfg_we,
  input  wire logic        [reab_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic        [reab_pkg::GOAL_W-1:0]  cfg_data
);

  localparam int CW = reab_pkg::COORD_W;
  localparam int DW = reab_pkg::DIM_W;
  localparam int WW = reab_pkg::WIDE_W;
  localparam int OW = reab_pkg::OFF_W;
  localparam int RW = reab_pkg::ROOT_W;
  localparam int GW = reab_pkg::GOAL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_WAIT_SQ, S_WAIT_DIV, S_OFF, S_APPLY, S_EDGE, S_CHECK, S_MARK
  } state_t;

  state_t state_r;

  // configuration
  logic signed [CW-1:0] bound_x_r, bound_y_r;
  logic        [DW-1:0] bound_w_r, bound_h_r;
  logic        [GW-1:0] goal_r;

  // working rectangle
  logic signed [CW-1:0] st_x_r, st_y_r;
  logic        [DW-1:0] st_w_r, st_h_r;
  logic signed [WW-1:0] x_r, y_r, w_r, h_r, rr_r, rb_r;
  logic [3:0]           done_r;     // left, top, right, bottom
  logic [1:0]           n_r;
  logic                 div0_r;

  // offset solve
  logic [reab_pkg::RAD_W-1:0] rad_r;
  logic [DW+1:0]              b_r;
  logic [DW-1:0]              den_r, sub_r;
  logic                       use_div_r, half_r, dbl_r;
  logic signed [OW-1:0]       off_r;
  logic                       sq_go_r, dv_go_r;

  logic                       out_valid_r;
  logic signed [CW-1:0]       out_x_r, out_y_r;
  logic        [DW-1:0]       out_w_r, out_h_r;
  logic        [1:0]          out_st_r;

  logic                       sq_done, dv_done;
  logic [RW-1:0]              sq_root;
  logic [GW-1:0]              dv_quo;

  reab_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go_r),
    .radicand (rad_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  reab_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dv_go_r),
    .num   (goal_r),
    .den   (den_r),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // ---- round preparation ----
  logic [DW-1:0]              w15, h15;
  logic                       p_div, p_half, p_dbl, p_sh3;
  logic [DW+1:0]              p_b;
  logic signed [DW+2:0]       p_d;
  logic [DW-1:0]              p_den, p_sub;
  logic signed [2*DW+5:0]     p_dsq;
  logic [reab_pkg::RAD_W-1:0] p_rad;

  always_comb begin
    w15    = w_r[DW-1:0];
    h15    = h_r[DW-1:0];
    p_div  = 1'b0;
    p_half = 1'b0;
    p_dbl  = 1'b0;
    p_sh3  = 1'b0;
    p_b    = {2'b00, w15} + {2'b00, h15};
    p_d    = $signed({3'b000, w15}) - $signed({3'b000, h15});
    p_den  = w15;
    p_sub  = h15;
    unique case (n_r)
      2'd0: ;
      2'd1: begin
        p_sh3 = 1'b1;
        if (done_r[0] || done_r[2]) begin
          p_b = {1'b0, w15, 1'b0} + {2'b00, h15};
          p_d = $signed({2'b00, w15, 1'b0}) - $signed({3'b000, h15});
        end else begin
          p_b = {2'b00, w15} + {1'b0, h15, 1'b0};
          p_d = $signed({2'b00, h15, 1'b0}) - $signed({3'b000, w15});
        end
      end
      2'd2: begin
        if (done_r[0] && done_r[2]) begin
          p_div  = 1'b1;
          p_half = 1'b1;
        end else if (done_r[1] && done_r[3]) begin
          p_div  = 1'b1;
          p_half = 1'b1;
          p_den  = h15;
          p_sub  = w15;
        end else begin
          p_dbl = 1'b1;
        end
      end
      2'd3: begin
        p_div = 1'b1;
        if (done_r[1] && done_r[3]) begin
          p_den = h15;
          p_sub = w15;
        end
      end
      default: ;
    endcase
    p_dsq = p_d * p_d;
    p_rad = reab_pkg::RAD_W'($unsigned(p_dsq))
          + (p_sh3 ? {2'b00, goal_r, 3'b000} : {3'b000, goal_r, 2'b00});
  end

  // ---- offset from root or quotient ----
  logic signed [RW+1:0] o_x, o_q4, o_sq;
  logic signed [OW-1:0] o_v, o_h, o_off;

  always_comb begin
    o_x   = $signed({2'b00, sq_root}) - $signed({3'b000, b_r});
    o_q4  = o_x[RW+1] ? ((o_x + (RW+2)'(3)) >>> 2) : (o_x >>> 2);
    o_sq  = dbl_r ? (o_q4 <<< 1) : o_q4;
    o_v   = $signed({2'b00, dv_quo}) - $signed({{(OW-DW){1'b0}}, sub_r});
    o_h   = o_v[OW-1] ? ((o_v + OW'(1)) >>> 1) : (o_v >>> 1);
    o_off = use_div_r ? (half_r ? o_h : o_v) : {{(OW-RW-2){o_sq[RW+1]}}, o_sq};
  end

  // ---- apply, contain, clip, mark ----
  logic signed [WW-1:0] off_e, dl, dt, dr, db, a_w, a_h;
  logic signed [WW-1:0] bx_e, by_e, br_e, bb_e;
  logic signed [WW-1:0] c_x, c_y, c_r, c_b, m_w, m_h;
  logic                 contained, empty;
  logic [3:0]           m_done;
  logic [2:0]           m_cnt;

  always_comb begin
    off_e = {{(WW-OW){off_r[OW-1]}}, off_r};
    dl    = done_r[0] ? '0 : off_e;
    dt    = done_r[1] ? '0 : off_e;
    dr    = done_r[2] ? '0 : off_e;
    db    = done_r[3] ? '0 : off_e;
    a_w   = w_r + dl + dr;
    a_h   = h_r + dt + db;

    bx_e  = {{(WW-CW){bound_x_r[CW-1]}}, bound_x_r};
    by_e  = {{(WW-CW){bound_y_r[CW-1]}}, bound_y_r};
    br_e  = bx_e + $signed({{(WW-DW){1'b0}}, bound_w_r});
    bb_e  = by_e + $signed({{(WW-DW){1'b0}}, bound_h_r});

    contained = (x_r >= bx_e) && (rr_r <= br_e) && (y_r >= by_e) && (rb_r <= bb_e);
    c_x = (x_r > bx_e) ? x_r : bx_e;
    c_y = (y_r > by_e) ? y_r : by_e;
    c_r = (rr_r < br_e) ? rr_r : br_e;
    c_b = (rb_r < bb_e) ? rb_r : bb_e;
    empty = (w_r == '0) || (h_r == '0) || (bound_w_r == '0) || (bound_h_r == '0)
         || (c_x >= c_r) || (c_y >= c_b);

    m_w    = rr_r - x_r;
    m_h    = rb_r - y_r;
    m_done = done_r | {rb_r == bb_e, rr_r == br_e, y_r == by_e, x_r == bx_e};
    m_cnt  = {2'b00, m_done[0]} + {2'b00, m_done[1]}
           + {2'b00, m_done[2]} + {2'b00, m_done[3]};
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_x_r <= '0;
      bound_y_r <= '0;
      bound_w_r <= '0;
      bound_h_r <= '0;
      goal_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        reab_pkg::CFG_BOUND_X:      bound_x_r <= cfg_data[CW-1:0];
        reab_pkg::CFG_BOUND_Y:      bound_y_r <= cfg_data[CW-1:0];
        reab_pkg::CFG_BOUND_WIDTH:  bound_w_r <= cfg_data[DW-1:0];
        reab_pkg::CFG_BOUND_HEIGHT: bound_h_r <= cfg_data[DW-1:0];
        reab_pkg::CFG_GOAL_AREA:    goal_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sq_go_r     <= 1'b0;
      dv_go_r     <= 1'b0;
      n_r         <= '0;
      done_r      <= '0;
      div0_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      sq_go_r     <= 1'b0;
      dv_go_r     <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            st_x_r  <= in_start_x;
            st_y_r  <= in_start_y;
            st_w_r  <= in_start_width;
            st_h_r  <= in_start_height;
            x_r     <= {{(WW-CW){in_start_x[CW-1]}}, in_start_x};
            y_r     <= {{(WW-CW){in_start_y[CW-1]}}, in_start_y};
            w_r     <= {{(WW-DW){1'b0}}, in_start_width};
            h_r     <= {{(WW-DW){1'b0}}, in_start_height};
            n_r     <= '0;
            done_r  <= '0;
            div0_r  <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          rad_r     <= p_rad;
          b_r       <= p_b;
          den_r     <= p_den;
          sub_r     <= p_sub;
          use_div_r <= p_div;
          half_r    <= p_half;
          dbl_r     <= p_dbl;
          if (!p_div) begin
            sq_go_r <= 1'b1;
            state_r <= S_WAIT_SQ;
          end else if (p_den == '0) begin
            // zero side: no offset this round
            div0_r  <= 1'b1;
            off_r   <= '0;
            state_r <= S_APPLY;
          end else begin
            dv_go_r <= 1'b1;
            state_r <= S_WAIT_DIV;
          end
        end
        S_WAIT_SQ: begin
          if (sq_done) state_r <= S_OFF;
        end
        S_WAIT_DIV: begin
          if (dv_done) state_r <= S_OFF;
        end
        S_OFF: begin
          off_r   <= o_off;
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          x_r     <= x_r - dl;
          y_r     <= y_r - dt;
          w_r     <= a_w[WW-1] ? '0 : a_w;
          h_r     <= a_h[WW-1] ? '0 : a_h;
          state_r <= S_EDGE;
        end
        S_EDGE: begin
          rr_r    <= x_r + w_r;
          rb_r    <= y_r + h_r;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (contained) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r[CW-1:0];
            out_y_r     <= y_r[CW-1:0];
            out_w_r     <= w_r[DW-1:0];
            out_h_r     <= h_r[DW-1:0];
            out_st_r    <= div0_r ? reab_pkg::STAT_DIV0 : reab_pkg::STAT_OK;
            state_r     <= S_IDLE;
          end else begin
            x_r     <= empty ? '0 : c_x;
            y_r     <= empty ? '0 : c_y;
            rr_r    <= empty ? '0 : c_r;
            rb_r    <= empty ? '0 : c_b;
            state_r <= S_MARK;
          end
        end
        S_MARK: begin
          w_r    <= m_w;
          h_r    <= m_h;
          done_r <= m_done;
          if (m_cnt == 3'd4) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r[CW-1:0];
            out_y_r     <= y_r[CW-1:0];
            out_w_r     <= m_w[DW-1:0];
            out_h_r     <= m_h[DW-1:0];
            out_st_r    <= div0_r ? reab_pkg::STAT_DIV0 : reab_pkg::STAT_OK;
            state_r     <= S_IDLE;
          end else if (m_cnt[1:0] == n_r) begin
            // no new edge reached: later rounds never run, return the start
            out_valid_r <= 1'b1;
            out_x_r     <= st_x_r;
            out_y_r     <= st_y_r;
            out_w_r     <= st_w_r;
            out_h_r     <= st_h_r;
            out_st_r    <= reab_pkg::STAT_FALL;
            state_r     <= S_IDLE;
          end else begin
            n_r     <= m_cnt[1:0];
            state_r <= S_PREP;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_width  = out_w_r;
  assign out_height = out_h_r;
  assign out_status = out_st_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still working");

  a_sq_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_go_r |-> (state_r == S_WAIT_SQ))
    else $error("root unit launched outside its wait state");

  a_dv_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dv_go_r |-> (state_r == S_WAIT_DIV) && (den_r != '0))
    else $error("divider launched with zero divisor or outside its wait");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire

// ===== verif/rect_expand_to_area_bounded_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_expand_to_area_bounded_tb
// Drives start rectangles through the bounded area expander under several
// bound and goal settings and checks every result against a local predictor.
// ----------------------------------------------------------------------------
module rect_expand_to_area_bounded_tb;

  typedef struct {
    logic signed [reab_pkg::COORD_W-1:0] x;
    logic signed [reab_pkg::COORD_W-1:0] y;
    logic [reab_pkg::DIM_W-1:0]          w;
    logic [reab_pkg::DIM_W-1:0]          h;
    logic [1:0]                          status;
  } rect_res_t;

  // settings mirrored from the configuration writes
  longint bnd_x, bnd_y, bnd_w, bnd_h, goal;

  class area_scoreboard;
    rect_res_t pending[$];
    int        errors;
    int        checked;
    bit        dz;

    function longint isqrt(longint v);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - res - bitv;
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    function longint root(longint a, longint b, longint c);
      longint disc, s;
      disc = b * b - 4 * a * c;
      s = (disc > 0) ? isqrt(disc) : 0;
      return (s - b) / 2 / a;
    endfunction

    function longint four_edge(longint w, longint h);
      return root(1, w + h, w * h - goal) / 2;
    endfunction

    function longint edge_offset(int n, longint w, longint h, bit d[4]);
      case (n)
        0: return four_edge(w, h);
        1: begin
          if (d[0] || d[2]) return root(2, w * 2 + h, w * h - goal);
          return root(2, w + h * 2, w * h - goal);
        end
        2: begin
          if (d[0] && d[2]) begin
            if (w == 0) begin dz = 1; return 0; end
            return (goal / w - h) / 2;
          end
          if (d[1] && d[3]) begin
            if (h == 0) begin dz = 1; return 0; end
            return (goal / h - w) / 2;
          end
          return four_edge(w, h) * 2;
        end
        default: begin
          if (!d[1] || !d[3]) begin
            if (w == 0) begin dz = 1; return 0; end
            return goal / w - h;
          end
          if (h == 0) begin dz = 1; return 0; end
          return goal / h - w;
        end
      endcase
    endfunction

    function rect_res_t pack_rect(longint x, longint y, longint w, longint h,
                                  logic [1:0] st);
      rect_res_t r;
      r.x = x[reab_pkg::COORD_W-1:0];
      r.y = y[reab_pkg::COORD_W-1:0];
      r.w = w[reab_pkg::DIM_W-1:0];
      r.h = h[reab_pkg::DIM_W-1:0];
      r.status = st;
      return r;
    endfunction

    function rect_res_t expand(longint sx, longint sy, longint sw, longint sh);
      bit d[4];
      int n, k;
      longint x, y, w, h, off, dl, dt, dr, db, rx, ry, rr, rb, br, bb;
      d = '{0, 0, 0, 0};
      n = 0;
      x = sx; y = sy; w = sw; h = sh;
      br = bnd_x + bnd_w;
      bb = bnd_y + bnd_h;
      dz = 0;
      for (int i = 0; i < 4; i++) begin
        if (n != i) continue;
        off = edge_offset(n, w, h, d);
        dl = d[0] ? 0 : off;
        dt = d[1] ? 0 : off;
        dr = d[2] ? 0 : off;
        db = d[3] ? 0 : off;
        x = x - dl;
        y = y - dt;
        w = w + dl + dr;
        if (w < 0) w = 0;
        h = h + dt + db;
        if (h < 0) h = 0;
        if (x >= bnd_x && x + w <= br && y >= bnd_y && y + h <= bb)
          return pack_rect(x, y, w, h, dz ? reab_pkg::STAT_DIV0 : reab_pkg::STAT_OK);
        if (w == 0 || h == 0 || bnd_w == 0 || bnd_h == 0) begin
          rx = 0; ry = 0; rr = 0; rb = 0;
        end else begin
          rx = (x > bnd_x) ? x : bnd_x;
          ry = (y > bnd_y) ? y : bnd_y;
          rr = (x + w < br) ? x + w : br;
          rb = (y + h < bb) ? y + h : bb;
          if (rx >= rr || ry >= rb) begin
            rx = 0; ry = 0; rr = 0; rb = 0;
          end
        end
        x = rx; y = ry; w = rr - rx; h = rb - ry;
        if (x == bnd_x) d[0] = 1;
        if (y == bnd_y) d[1] = 1;
        if (x + w == br) d[2] = 1;
        if (y + h == bb) d[3] = 1;
        n = 0;
        for (k = 0; k < 4; k++) n += d[k];
        if (n == 4)
          return pack_rect(x, y, w, h, dz ? reab_pkg::STAT_DIV0 : reab_pkg::STAT_OK);
      end
      return pack_rect(sx, sy, sw, sh, reab_pkg::STAT_FALL);
    endfunction

    function void note_start(longint sx, longint sy, longint sw, longint sh);
      pending = {pending, expand(sx, sy, sw, sh)};
    endfunction

    function void check_result(rect_res_t got);
      rect_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending: x=%0d y=%0d", got.x, got.y);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.x !== e.x) begin
        $error("out_x expected %0d got %0d", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("out_y expected %0d got %0d", e.y, got.y); errors++;
      end
      if (got.w !== e.w) begin
        $error("out_width expected %0d got %0d", e.w, got.w); errors++;
      end
      if (got.h !== e.h) begin
        $error("out_height expected %0d got %0d", e.h, got.h); errors++;
      end
      if (got.status !== e.status) begin
        $error("out_status expected %0d got %0d", e.status, got.status); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [reab_pkg::COORD_W-1:0] in_start_x = '0, in_start_y = '0;
  logic [reab_pkg::DIM_W-1:0] in_start_width = '0, in_start_height = '0;
  logic out_valid;
  logic signed [reab_pkg::COORD_W-1:0] out_x, out_y;
  logic [reab_pkg::DIM_W-1:0] out_width, out_height;
  logic [1:0] out_status;
  logic cfg_we = 0;
  logic [reab_pkg::IDX_W-1:0] cfg_index = '0;
  logic [reab_pkg::GOAL_W-1:0] cfg_data = '0;

  area_scoreboard sb = new();
  int stat_seen[3];

  always #2 clk = ~clk;

  rect_expand_to_area_bounded uut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      rect_res_t r;
      r.x = out_x; r.y = out_y; r.w = out_width; r.h = out_height;
      r.status = out_status;
      if (out_status < 3) stat_seen[out_status]++;
      sb.check_result(r);
    end
  end

  task automatic write_reg(logic [reab_pkg::IDX_W-1:0] idx,
                           logic [reab_pkg::GOAL_W-1:0] val);
    @(negedge clk);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    case (idx)
      reab_pkg::CFG_BOUND_X:
        bnd_x = longint'($signed(val[reab_pkg::COORD_W-1:0]));
      reab_pkg::CFG_BOUND_Y:
        bnd_y = longint'($signed(val[reab_pkg::COORD_W-1:0]));
      reab_pkg::CFG_BOUND_WIDTH:  bnd_w = val[reab_pkg::DIM_W-1:0];
      reab_pkg::CFG_BOUND_HEIGHT: bnd_h = val[reab_pkg::DIM_W-1:0];
      reab_pkg::CFG_GOAL_AREA:    goal = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_bounds(int bx, int by, int bw, int bh, int g);
    write_reg(reab_pkg::CFG_BOUND_X, bx[reab_pkg::GOAL_W-1:0]);
    write_reg(reab_pkg::CFG_BOUND_Y, by[reab_pkg::GOAL_W-1:0]);
    write_reg(reab_pkg::CFG_BOUND_WIDTH, bw[reab_pkg::GOAL_W-1:0]);
    write_reg(reab_pkg::CFG_BOUND_HEIGHT, bh[reab_pkg::GOAL_W-1:0]);
    write_reg(reab_pkg::CFG_GOAL_AREA, g[reab_pkg::GOAL_W-1:0]);
  endtask

  // one transfer: hold start until busy is low at a rising edge
  task automatic send_rect(int sx, int sy, int sw, int sh);
    @(negedge clk);
    start = 1;
    in_start_x = sx[reab_pkg::COORD_W-1:0]; in_start_y = sy[reab_pkg::COORD_W-1:0];
    in_start_width = sw[reab_pkg::DIM_W-1:0]; in_start_height = sh[reab_pkg::DIM_W-1:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_start(longint'(in_start_x), longint'(in_start_y),
                  in_start_width, in_start_height);
  endtask

  int burst_left = 0;

  task automatic send_paced(int sx, int sy, int sw, int sh);
    send_rect(sx, sy, sw, sh);
    if (burst_left == 0) begin
      @(negedge clk);
      start = 0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    @(negedge clk);
    start = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (160) @(negedge clk);
  endtask

  // near-bound start rectangles drive multi-round behaviour
  task automatic random_rect;
    int sx, sy, sw, sh, mode;
    mode = $urandom_range(0, 9);
    if (mode < 7 && bnd_w > 0 && bnd_h > 0) begin
      sw = $urandom_range(0, (bnd_w > 300) ? 300 : bnd_w);
      sh = $urandom_range(0, (bnd_h > 300) ? 300 : bnd_h);
      sx = int'(bnd_x + $signed($urandom_range(0, bnd_w + 40)) - 20);
      sy = int'(bnd_y + $signed($urandom_range(0, bnd_h + 40)) - 20);
    end else begin
      sx = $signed(16'($urandom));
      sy = $signed(16'($urandom));
      sw = $urandom_range(0, 32767);
      sh = $urandom_range(0, 32767);
    end
    send_paced(16'(sx), 16'(sy), sw, sh);
  endtask

  int cfg_sets[6][5] = '{
    '{0, 0, 100, 80, 4000},
    '{-32768, -32768, 32767, 32767, 2147483647},
    '{32767, 32767, 0, 0, 0},
    '{-50, 20, 60, 60, 900},
    '{100, -200, 400, 30, 50000},
    '{0, 0, 1000, 1000, 100}
  };

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    set_bounds(0, 0, 100, 80, 4000);
    // directed: extremes, containment, division by zero, fall through
    send_paced(0, 0, 10, 10);
    send_paced(10, 10, 0, 0);
    send_paced(-32768, -32768, 32767, 32767);
    send_paced(32767, 32767, 32767, 32767);
    send_paced(-32768, 32767, 0, 32767);
    send_paced(90, 70, 10, 10);
    send_paced(0, 0, 100, 80);
    send_paced(-5, 10, 200, 5);
    send_paced(10, -5, 5, 200);
    send_paced(500, 500, 1, 1);
    send_paced(0, 0, 0, 80);
    drain();
    set_bounds(0, 0, 0, 0, 0);
    send_paced(0, 0, 0, 0);
    send_paced(5, 5, 3, 3);
    send_paced(-1, -1, 1, 1);
    drain();
    set_bounds(0, 0, 10, 10, 2147483647);
    send_paced(0, 0, 5, 5);
    send_paced(0, 0, 10, 0);
    send_paced(-3, 2, 4, 4);
    send_paced(-32768, -32768, 32767, 32767);
    drain();
    for (int p = 0; p < 6; p++) begin
      set_bounds(cfg_sets[p][0], cfg_sets[p][1], cfg_sets[p][2], cfg_sets[p][3],
                 cfg_sets[p][4]);
      for (int i = 0; i < 200; i++) random_rect();
      drain();
    end
    for (int p = 0; p < 3; p++) begin
      set_bounds($signed(16'($urandom)) / 2, $signed(16'($urandom)) / 2,
                 $urandom_range(0, 2000), $urandom_range(0, 2000),
                 $urandom_range(0, 32'h7fffffff) >> $urandom_range(0, 31));
      for (int i = 0; i < 200; i++) random_rect();
      drain();
    end
    $display("checked %0d results: ok %0d, div-by-zero %0d, fall-through %0d",
             sb.checked, stat_seen[0], stat_seen[1], stat_seen[2]);
    $display("nine bound/goal settings plus directed edge cases");
    if (sb.errors == 0) begin
      $display("rect_expand_to_area_bounded_tb: PASS");
    end else begin
      $display("rect_expand_to_area_bounded_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("rect_expand_to_area_bounded_tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/reab_pkg.sv
hdl/reab_isqrt.sv
hdl/reab_div.sv
hdl/rect_expand_to_area_bounded.sv
verif/rect_expand_to_area_bounded_tb.sv
